// ===== src/prbh_pkg.sv =====
// Package with the shared constants, types and functions of the range header parser.
`timescale 1ns / 1ps
`default_nettype none

package prbh_pkg;

    localparam int FIELD_LIMIT_DEF = 31;
    localparam int SIZE_W = 63;
    localparam int VALUE_W = 64;
    localparam int ACC_W = 64;

    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS = 8'h2B;
    localparam logic [7:0] CHAR_DASH = 8'h2D;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_B = 8'h62;

    localparam logic [2:0] PREFIX_LEN = 3'd6;

    localparam logic [ACC_W-1:0] SIGN64 = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [SIZE_W-1:0] MAX63 = {SIZE_W{1'b1}};

    typedef struct packed {
        logic found;
        logic negative;
        logic end_nonempty;
        logic [ACC_W-1:0] start_acc;
        logic [ACC_W-1:0] end_acc;
    } snap_t;

    // Characters of the "bytes=" prefix by position.
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0: ch = 8'h62;
            3'd1: ch = 8'h79;
            3'd2: ch = 8'h74;
            3'd3: ch = 8'h65;
            3'd4: ch = 8'h73;
            3'd5: ch = 8'h3D;
            default: ch = CHAR_NUL;
        endcase
        return ch;
    endfunction

    // One decimal digit into a magnitude that saturates at 2^63.
    function automatic logic [ACC_W-1:0] acc_step(input logic [ACC_W-1:0] acc,
                                                  input logic [3:0] digit);
        logic [ACC_W+3:0] sum;
        sum = {acc, 3'b000} + {2'b00, acc, 1'b0} + {{ACC_W{1'b0}}, digit};
        if (sum > {4'b0000, SIGN64}) begin
            return SIGN64;
        end
        return sum[ACC_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/parse_byte_range_header_unit.sv =====
// Top level of the streaming parser for the value of an HTTP Range header.
//
// Header text enters one byte per transaction on the s_ channel; s_tlast marks the
// final byte of a header. For each header one result transaction leaves on the m_
// channel: range_found, satisfiable, start_offset and end_offset. The file size is
// written through the cfg_ channel; the user must do so only while no header is
// in flight, as the block itself does not enforce it.
// Throughput is one byte per cycle, with no gaps between headers, while s_tready is
// high. The last byte of a header is captured by the input register on acceptance;
// its result then passes through the end-of-header snapshot, the offset stage and
// the output register in turn.
//
// Reset clears the parse state, the file size and all valid flags. When the
// receiver stalls, the result waits in the output register while the input
// register, the parser and the offset stage keep taking bytes; s_tready falls
// only when a further completed header finds every later stage occupied.
`timescale 1ns / 1ps
`default_nettype none

module parse_byte_range_header_unit #(
    parameter int FIELD_LIMIT = prbh_pkg::FIELD_LIMIT_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [7:0]     s_tdata,   // [7:0] header_byte
    input  wire logic           s_tlast,   // last_byte
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [135:0]        m_tdata,   // [0] range_found, [1] satisfiable,
                                           // [64:2] start_offset, [128:65] end_offset
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [62:0]    cfg_data   // object_size
);

    logic                               in_valid_reg;
    logic [7:0]                         in_byte_reg;
    logic                               in_last_reg;
    logic                               byte_take;
    logic                               snap_valid;
    prbh_pkg::snap_t                    snap;
    logic [prbh_pkg::SIZE_W-1:0]        object_size_reg;
    logic                               val_valid_reg;
    logic                               val_found_reg;
    logic [prbh_pkg::SIZE_W-1:0]        val_start_reg, val_start_next;
    logic [prbh_pkg::VALUE_W-1:0]       val_end_reg, val_end_next;
    logic                               out_valid_reg;
    logic                               out_found_reg;
    logic                               out_sat_reg;
    logic                               out_sat_next;
    logic [prbh_pkg::SIZE_W-1:0]        out_start_reg;
    logic [prbh_pkg::VALUE_W-1:0]       out_end_reg;
    logic                               out_free, val_free, in_free;

    assign out_free = !out_valid_reg || m_tready;
    assign val_free = !val_valid_reg || out_free;
    assign in_free = !in_valid_reg || byte_take;
    assign s_tready = in_free;
    assign cfg_ready = 1'b1;

    prbh_parser #(
        .FIELD_LIMIT(FIELD_LIMIT)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_valid(in_valid_reg),
        .byte_data (in_byte_reg),
        .byte_last (in_last_reg),
        .byte_take (byte_take),
        .snap_take (val_free),
        .snap_valid(snap_valid),
        .snap      (snap)
    );

    always_comb begin
        val_start_next = snap.start_acc[prbh_pkg::ACC_W-1] ? prbh_pkg::MAX63
                                                           : snap.start_acc[prbh_pkg::SIZE_W-1:0];
        if (!snap.end_nonempty) begin
            val_end_next = {1'b0, object_size_reg} - 64'd1;
        end else if (snap.negative) begin
            val_end_next = 64'd0 - snap.end_acc;
        end else if (snap.end_acc[prbh_pkg::ACC_W-1]) begin
            val_end_next = {1'b0, prbh_pkg::MAX63};
        end else begin
            val_end_next = snap.end_acc;
        end
        if (!snap.found) begin
            val_start_next = '0;
            val_end_next = '0;
        end
        out_sat_next = val_found_reg &&
                       ($signed({1'b0, val_start_reg}) <= $signed(val_end_reg)) &&
                       ($signed(val_end_reg) < $signed({1'b0, object_size_reg}));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            val_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            object_size_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                object_size_reg <= cfg_data;
            end
            if (in_free) begin
                in_valid_reg <= s_tvalid;
                in_byte_reg <= s_tdata;
                in_last_reg <= s_tlast;
            end
            if (val_free) begin
                val_valid_reg <= snap_valid;
                val_found_reg <= snap.found;
                val_start_reg <= val_start_next;
                val_end_reg <= val_end_next;
            end
            if (out_free) begin
                out_valid_reg <= val_valid_reg;
                out_found_reg <= val_found_reg;
                out_sat_reg <= out_sat_next;
                out_start_reg <= val_start_reg;
                out_end_reg <= val_end_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {7'b0000000, out_end_reg, out_start_reg, out_sat_reg, out_found_reg};

    a_sat_needs_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_found_reg || !out_sat_reg))
        else $error("satisfiable set without a range");

    a_no_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !out_found_reg) |-> (out_start_reg == '0 && out_end_reg == '0))
        else $error("offsets not zero when no range was found");

    a_result_from_value: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(val_valid_reg))
        else $error("result appeared without a staged value");

endmodule

`default_nettype wire

// ===== src/prbh_parser.sv =====
// Per-byte parse state of the range header and the snapshot taken on the last byte.
`timescale 1ns / 1ps
`default_nettype none

module prbh_parser #(
    parameter int FIELD_LIMIT = prbh_pkg::FIELD_LIMIT_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                byte_valid,
    input  wire logic [7:0]          byte_data,
    input  wire logic                byte_last,
    output logic                     byte_take,
    input  wire logic                snap_take,
    output logic                     snap_valid,
    output prbh_pkg::snap_t          snap
);

    localparam int CNT_W = $clog2(FIELD_LIMIT + 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(FIELD_LIMIT);

    typedef enum logic [1:0] {PH_PREFIX, PH_START, PH_END} phase_t;
    typedef enum logic [1:0] {NUM_SKIP, NUM_IN, NUM_STOP} num_t;

    phase_t                          phase_reg, phase_next;
    num_t                            stage_reg, stage_next, f_stage;
    logic [2:0]                      match_reg, match_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic [prbh_pkg::ACC_W-1:0]      start_reg, start_next;
    logic [prbh_pkg::ACC_W-1:0]      end_reg, end_next;
    logic [prbh_pkg::ACC_W-1:0]      acc_sel, f_acc;
    logic                            neg_reg, neg_next, f_neg;
    logic                            nonempty_reg, nonempty_next;
    logic                            ended_reg, ended_next;
    logic                            snap_valid_reg;
    prbh_pkg::snap_t                 snap_reg;
    logic                            is_digit, is_space, is_sign;
    logic                            snap_free, go, close;

    assign snap_free = !snap_valid_reg || snap_take;
    assign go = byte_valid && (!byte_last || snap_free);
    assign close = go && byte_last;
    assign byte_take = go;
    assign snap_valid = snap_valid_reg;
    assign snap = snap_reg;

    always_comb begin
        is_digit = (byte_data >= prbh_pkg::CHAR_ZERO) && (byte_data <= prbh_pkg::CHAR_NINE);
        is_space = (byte_data == prbh_pkg::CHAR_SPACE) ||
                   ((byte_data >= prbh_pkg::CHAR_TAB) && (byte_data <= prbh_pkg::CHAR_CR));
        is_sign = (byte_data == prbh_pkg::CHAR_PLUS) || (byte_data == prbh_pkg::CHAR_DASH);
        acc_sel = (phase_reg == PH_END) ? end_reg : start_reg;
        f_stage = stage_reg;
        f_neg = neg_reg;
        f_acc = acc_sel;
        if ((stage_reg == NUM_SKIP) && is_space) begin
            f_stage = stage_reg;
        end else if ((stage_reg == NUM_SKIP) && is_sign) begin
            f_neg = (byte_data == prbh_pkg::CHAR_DASH);
            f_stage = NUM_IN;
        end else if (stage_reg == NUM_STOP) begin
            f_stage = stage_reg;
        end else if (!is_digit) begin
            f_stage = NUM_STOP;
        end else begin
            f_stage = NUM_IN;
            f_acc = prbh_pkg::acc_step(acc_sel, byte_data[3:0]);
        end
    end

    always_comb begin
        phase_next = phase_reg;
        stage_next = stage_reg;
        match_next = match_reg;
        cnt_next = cnt_reg;
        start_next = start_reg;
        end_next = end_reg;
        neg_next = neg_reg;
        nonempty_next = nonempty_reg;
        ended_next = ended_reg;
        if (ended_reg) begin
            ended_next = 1'b1;
        end else if (byte_data == prbh_pkg::CHAR_NUL) begin
            ended_next = 1'b1;
        end else begin
            case (phase_reg)
                PH_PREFIX: begin
                    if ((match_reg < prbh_pkg::PREFIX_LEN) &&
                        (byte_data == prbh_pkg::prefix_char(match_reg))) begin
                        match_next = match_reg + 3'd1;
                    end else begin
                        match_next = (byte_data == prbh_pkg::CHAR_B) ? 3'd1 : 3'd0;
                    end
                    if (match_next >= prbh_pkg::PREFIX_LEN) begin
                        phase_next = PH_START;
                        cnt_next = '0;
                        stage_next = NUM_SKIP;
                        neg_next = 1'b0;
                    end
                end
                PH_START: begin
                    if (byte_data == prbh_pkg::CHAR_DASH) begin
                        phase_next = PH_END;
                        cnt_next = '0;
                        stage_next = NUM_SKIP;
                        neg_next = 1'b0;
                    end else if (cnt_reg < CNT_LIMIT) begin
                        cnt_next = cnt_reg + 1'b1;
                        stage_next = f_stage;
                        neg_next = f_neg;
                        start_next = f_acc;
                    end
                end
                PH_END: begin
                    if (cnt_reg < CNT_LIMIT) begin
                        cnt_next = cnt_reg + 1'b1;
                        nonempty_next = 1'b1;
                        stage_next = f_stage;
                        neg_next = f_neg;
                        end_next = f_acc;
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_PREFIX;
            stage_reg <= NUM_SKIP;
            match_reg <= '0;
            cnt_reg <= '0;
            start_reg <= '0;
            end_reg <= '0;
            neg_reg <= 1'b0;
            nonempty_reg <= 1'b0;
            ended_reg <= 1'b0;
            snap_valid_reg <= 1'b0;
        end else begin
            if (close) begin
                snap_valid_reg <= 1'b1;
            end else if (snap_valid_reg && snap_take) begin
                snap_valid_reg <= 1'b0;
            end
            if (close) begin
                snap_reg.found <= (phase_next == PH_END);
                snap_reg.negative <= neg_next;
                snap_reg.end_nonempty <= nonempty_next;
                snap_reg.start_acc <= start_next;
                snap_reg.end_acc <= end_next;
                phase_reg <= PH_PREFIX;
                stage_reg <= NUM_SKIP;
                match_reg <= '0;
                cnt_reg <= '0;
                start_reg <= '0;
                end_reg <= '0;
                neg_reg <= 1'b0;
                nonempty_reg <= 1'b0;
                ended_reg <= 1'b0;
            end else if (go) begin
                phase_reg <= phase_next;
                stage_reg <= stage_next;
                match_reg <= match_next;
                cnt_reg <= cnt_next;
                start_reg <= start_next;
                end_reg <= end_next;
                neg_reg <= neg_next;
                nonempty_reg <= nonempty_next;
                ended_reg <= ended_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== tb/prbh_range_checker.sv =====
// Checker that predicts the parse result of each header and compares the m_ channel with it.
`timescale 1ns / 1ps

module prbh_range_checker #(
    parameter int FIELD_LIMIT = prbh_pkg::FIELD_LIMIT_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    input  wire logic           s_tready,
    input  wire logic [7:0]     s_tdata,   // [7:0] header_byte
    input  wire logic           s_tlast,   // last_byte
    input  wire logic           m_tvalid,
    input  wire logic           m_tready,
    input  wire logic [135:0]   m_tdata,   // [0] range_found, [1] satisfiable,
                                           // [64:2] start_offset, [128:65] end_offset
    input  wire logic           cfg_valid,
    input  wire logic           cfg_ready,
    input  wire logic [62:0]    cfg_data,  // object_size
    output int                  error_count,
    output int                  pending_count
);

    typedef enum logic [1:0] {SEEK_PREFIX, IN_START, IN_END} parse_phase_t;
    typedef enum logic [1:0] {SKIP_BLANKS, IN_DIGITS, STOPPED} digit_stage_t;

    typedef struct packed {
        logic [63:0] end_offset;
        logic [62:0] start_offset;
        logic        satisfiable;
        logic        range_found;
    } range_result_t;

    localparam logic [47:0] PREFIX_TEXT = "bytes=";

    range_result_t expected_ranges[$];
    logic [62:0]   object_size;
    parse_phase_t  phase;
    digit_stage_t  stage;
    logic [2:0]    matched;
    logic [63:0]   start_mag;
    logic [63:0]   end_mag;
    int            field_chars;
    logic          minus;
    logic          end_seen;
    logic          text_done;

    task automatic clear_parse();
        phase = SEEK_PREFIX;
        stage = SKIP_BLANKS;
        matched = '0;
        start_mag = '0;
        end_mag = '0;
        field_chars = 0;
        minus = 1'b0;
        end_seen = 1'b0;
        text_done = 1'b0;
    endtask

    task automatic absorb_digit(inout logic [63:0] mag, input logic [7:0] c);
        logic        skip;
        logic [63:0] d;
        skip = 1'b0;
        if (stage == SKIP_BLANKS) begin
            if (c == prbh_pkg::CHAR_SPACE ||
                (c >= prbh_pkg::CHAR_TAB && c <= prbh_pkg::CHAR_CR)) begin
                skip = 1'b1;
            end else if (c == prbh_pkg::CHAR_PLUS || c == prbh_pkg::CHAR_DASH) begin
                minus = (c == prbh_pkg::CHAR_DASH);
                stage = IN_DIGITS;
                skip = 1'b1;
            end
        end
        if (!skip && stage != STOPPED) begin
            if (c < prbh_pkg::CHAR_ZERO || c > prbh_pkg::CHAR_NINE) begin
                stage = STOPPED;
            end else begin
                stage = IN_DIGITS;
                d = 64'(c - prbh_pkg::CHAR_ZERO);
                if (mag >= prbh_pkg::SIGN64 || mag > (prbh_pkg::SIGN64 - d) / 64'd10) begin
                    mag = prbh_pkg::SIGN64;
                end else begin
                    mag = mag * 64'd10 + d;
                end
            end
        end
    endtask

    task automatic take_char(input logic [7:0] c);
        if (!text_done) begin
            if (c == prbh_pkg::CHAR_NUL) begin
                text_done = 1'b1;
            end else begin
                case (phase)
                    SEEK_PREFIX: begin
                        if (matched < 3'd6 && c == PREFIX_TEXT[47 - 8 * matched -: 8]) begin
                            matched = matched + 3'd1;
                        end else begin
                            matched = (c == prbh_pkg::CHAR_B) ? 3'd1 : 3'd0;
                        end
                        if (matched >= 3'd6) begin
                            phase = IN_START;
                            field_chars = 0;
                            stage = SKIP_BLANKS;
                            minus = 1'b0;
                        end
                    end
                    IN_START: begin
                        if (c == prbh_pkg::CHAR_DASH) begin
                            phase = IN_END;
                            field_chars = 0;
                            stage = SKIP_BLANKS;
                            minus = 1'b0;
                        end else if (field_chars < FIELD_LIMIT) begin
                            field_chars++;
                            absorb_digit(start_mag, c);
                        end
                    end
                    default: begin
                        if (field_chars < FIELD_LIMIT) begin
                            field_chars++;
                            end_seen = 1'b1;
                            absorb_digit(end_mag, c);
                        end
                    end
                endcase
            end
        end
    endtask

    function automatic range_result_t finish_header();
        range_result_t r;
        logic [63:0]   s;
        logic [63:0]   e;
        r = '0;
        if (phase == IN_END) begin
            s = (start_mag >= prbh_pkg::SIGN64) ? {1'b0, prbh_pkg::MAX63} : start_mag;
            if (!end_seen) begin
                e = {1'b0, object_size} - 64'd1;
            end else if (minus) begin
                e = 64'd0 - end_mag;
            end else begin
                e = (end_mag >= prbh_pkg::SIGN64) ? {1'b0, prbh_pkg::MAX63} : end_mag;
            end
            r.range_found = 1'b1;
            r.start_offset = s[62:0];
            r.end_offset = e;
            r.satisfiable = ($signed(s) <= $signed(e)) &&
                            ($signed(e) < $signed({1'b0, object_size}));
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        error_count++;
        $display("%0t: %s mismatch, expected 0x%h, actual 0x%h", $time, field, want, got);
    endtask

    always @(posedge aclk) begin : watch
        range_result_t want;
        range_result_t got;
        if (!aresetn) begin
            clear_parse();
            object_size = '0;
            expected_ranges.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                object_size = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                take_char(s_tdata);
                if (s_tlast) begin
                    expected_ranges.push_back(finish_header());
                    clear_parse();
                end
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[128:0];
                if (expected_ranges.size() == 0) begin
                    error_count++;
                    $display("%0t: result transaction with none expected, actual 0x%h",
                             $time, got);
                end else begin
                    want = expected_ranges.pop_front();
                    if (got.range_found !== want.range_found) begin
                        flag_mismatch("range_found", want.range_found, got.range_found);
                    end
                    if (got.satisfiable !== want.satisfiable) begin
                        flag_mismatch("satisfiable", want.satisfiable, got.satisfiable);
                    end
                    if (got.start_offset !== want.start_offset) begin
                        flag_mismatch("start_offset", want.start_offset, got.start_offset);
                    end
                    if (got.end_offset !== want.end_offset) begin
                        flag_mismatch("end_offset", want.end_offset, got.end_offset);
                    end
                end
            end
        end
        pending_count = expected_ranges.size();
    end

endmodule

// ===== tb/parse_byte_range_header_unit_test.sv =====
// Testbench top that drives header text and the file size into the range header parser.
`timescale 1ns / 1ps

module parse_byte_range_header_unit_test;

    logic           aclk;
    logic           aresetn;
    logic           s_tvalid;
    logic           s_tready;
    logic [7:0]     s_tdata;   // [7:0] header_byte
    logic           s_tlast;   // last_byte
    logic           m_tvalid;
    logic           m_tready;
    logic [135:0]   m_tdata;   // [0] range_found, [1] satisfiable,
                               // [64:2] start_offset, [128:65] end_offset
    logic           cfg_valid;
    logic           cfg_ready;
    logic [62:0]    cfg_data;  // object_size
    int             error_count;
    int             pending_count;

    logic [7:0]     header_text[$];
    int             burst_left;
    int             bytes_sent;
    int             cycle_no;
    int             ready_mode;
    int             stall_left;

    parse_byte_range_header_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    prbh_range_checker range_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(negedge aclk) begin : receiver_pattern
        logic ready;
        if (cycle_no % 300 == 0) begin
            ready_mode = $urandom_range(0, 2);
        end
        cycle_no++;
        case (ready_mode)
            0: ready = 1'b1;
            1: ready = 1'($urandom_range(0, 1));
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    ready = 1'b0;
                end else begin
                    ready = 1'b1;
                    if ($urandom_range(0, 15) == 0) begin
                        stall_left = $urandom_range(5, 40);
                    end
                end
            end
        endcase
        m_tready <= ready;
    end

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            header_text.push_back(s[i]);
        end
    endtask

    task automatic add_noise(input int n);
        string pool;
        int    i;
        pool = "bytes=-+ 0123456789";
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                header_text.push_back(pool[$urandom_range(0, pool.len() - 1)]);
            end else begin
                header_text.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic add_number();
        int n;
        int r;
        int i;
        if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) begin
                r = $urandom_range(0, 5);
                header_text.push_back((r == 5) ? prbh_pkg::CHAR_SPACE
                                               : 8'(prbh_pkg::CHAR_TAB + r));
            end
        end
        r = $urandom_range(0, 7);
        if (r == 0) begin
            header_text.push_back(prbh_pkg::CHAR_PLUS);
        end else if (r == 1) begin
            header_text.push_back(prbh_pkg::CHAR_DASH);
        end
        r = $urandom_range(0, 19);
        n = (r < 14) ? $urandom_range(0, 4) : (r < 18) ? $urandom_range(5, 19) :
            $urandom_range(20, 40);
        for (i = 0; i < n; i++) begin
            header_text.push_back(8'(prbh_pkg::CHAR_ZERO + $urandom_range(0, 9)));
        end
        if ($urandom_range(0, 5) == 0) begin
            add_noise($urandom_range(1, 3));
        end
    endtask

    task automatic build_header();
        string prefix;
        int    r;
        prefix = "bytes=";
        r = $urandom_range(0, 9);
        if (r < 8) begin
            if ($urandom_range(0, 4) == 0) begin
                add_noise($urandom_range(1, 6));
            end
            add_text(prefix);
            add_number();
            if ($urandom_range(0, 11) != 0) begin
                header_text.push_back(prbh_pkg::CHAR_DASH);
            end
            if ($urandom_range(0, 3) != 0) begin
                add_number();
            end
            if ($urandom_range(0, 9) == 0) begin
                header_text.push_back(prbh_pkg::CHAR_NUL);
                add_noise($urandom_range(0, 8));
            end else if ($urandom_range(0, 7) == 0) begin
                add_noise($urandom_range(1, 4));
            end
        end else if (r == 8) begin
            add_text(prefix.substr(0, $urandom_range(0, 4)));
            add_noise($urandom_range(1, 10));
        end else begin
            add_noise($urandom_range(1, 16));
        end
    endtask

    task automatic push_header_byte(input logic [7:0] c, input logic last);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(40, 150);
                gap = 0;
            end else begin
                burst_left = $urandom_range(1, 12);
                gap = $urandom_range(1, 5);
            end
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_header();
        int i;
        for (i = 0; i < header_text.size(); i++) begin
            push_header_byte(header_text[i], i == header_text.size() - 1);
        end
        header_text.delete();
    endtask

    task automatic send_text(input string s);
        add_text(s);
        send_header();
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_count != 0) @(negedge aclk);
    endtask

    task automatic write_object_size(input logic [62:0] size);
        wait_drained();
        repeat (4) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= size;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int          phase_no;
        int          target;
        logic [62:0] size_setting;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        burst_left = 0;
        bytes_sent = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // The file size is still zero from reset, so an open end gives -1.
        send_text("bytes=0-");
        write_object_size(63'd1000);
        send_text("bytes=0-999");
        send_text("bytes=-");
        send_text("xbbytes= +12-\t-3");
        send_text("bytes=7");
        add_text("bytes=1-2");
        header_text.push_back(prbh_pkg::CHAR_NUL);
        send_text("9");
        send_text("bytes=99999999999999999999-99999999999999999999");
        send_text("bytes=5--99999999999999999999");
        send_text("bytes=12a3-4x5");
        send_text("bytes=+-5-+");
        add_text("bytes=");
        repeat (30) header_text.push_back(prbh_pkg::CHAR_ZERO);
        add_text("12-");
        repeat (32) header_text.push_back(prbh_pkg::CHAR_ZERO);
        send_text("5");
        header_text.push_back(8'hFF);
        send_header();
        header_text.push_back(prbh_pkg::CHAR_NUL);
        send_header();
        write_object_size(prbh_pkg::MAX63);
        send_text("bytes=0-");

        for (phase_no = 0; phase_no < 5; phase_no++) begin
            case (phase_no)
                0: size_setting = 63'($urandom_range(1, 3000));
                1: size_setting = '0;
                2: size_setting = prbh_pkg::MAX63;
                3: size_setting = 63'({$urandom, $urandom});
                default: size_setting = 63'd1;
            endcase
            write_object_size(size_setting);
            target = bytes_sent + 250;
            while (bytes_sent < target) begin
                build_header();
                send_header();
            end
        end

        wait_drained();
        repeat (10) @(negedge aclk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/prbh_pkg.sv
src/prbh_parser.sv
src/parse_byte_range_header_unit.sv
tb/prbh_range_checker.sv
tb/parse_byte_range_header_unit_test.sv
